// ----- hdl/mstt_pkg.sv -----
// Shared types and codes for the multi-slot timer table.
// Used by mstt_due and multi_slot_timer_table_top; depends on nothing.
package mstt_pkg;

  localparam int TIME_W    = 32;
  localparam int SLOT_ID_W = 3;
  localparam int MAX_SLOTS = 8;

  // Command codes carried by an input beat
  typedef enum logic [1:0] {
    CMD_CHECK  = 2'd0,
    CMD_ADD    = 2'd1,
    CMD_CANCEL = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  // Event codes carried by a result beat
  typedef enum logic [1:0] {
    EV_ADDED = 2'd0,
    EV_FULL  = 2'd1,
    EV_FIRED = 2'd2,
    EV_RSVD  = 2'd3
  } event_t;

  typedef struct packed {
    cmd_t                   cmd;
    logic [TIME_W-1:0]      now;
    logic [TIME_W-1:0]      duration;
    logic                   periodic;
    logic [SLOT_ID_W-1:0]   cancel_slot;
  } in_t;

  typedef struct packed {
    event_t                 event_res;
    logic [SLOT_ID_W-1:0]   slot_id;
    logic                   last_flag;
  } out_t;

endpackage

// ----- hdl/mstt_due.sv -----
// Shared expiry unit: wrapping elapsed time against a slot's wait.
// Depends on mstt_pkg for the time width.
module mstt_due (
  input  logic [mstt_pkg::TIME_W-1:0] now,
  input  logic [mstt_pkg::TIME_W-1:0] start_time,
  input  logic [mstt_pkg::TIME_W-1:0] wait_time,
  input  logic                        active,
  output logic                        due
);
  import mstt_pkg::*;

  logic [TIME_W-1:0] elapsed;

  // elapsed wraps modulo 2^32, then one unsigned compare
  assign elapsed = now - start_time;
  assign due     = active && (elapsed >= wait_time);

endmodule

// ----- hdl/multi_slot_timer_table_top.sv -----
// Multi-slot timer table: top level with sequencer and slot storage.
// Depends on mstt_pkg and mstt_due.
//
// An item is taken when start is high and busy is low. Add and cancel are
// handled from idle; an add's single result (slot or table full) shows on out_valid
// in the cycle after it is taken, and busy stays low. A check walks the slots
// one per cycle through a single subtract-and-compare unit, so it holds busy
// while it scans each slot and then flushes, sending the final fired beat, if
// any, with last_flag set. Fired beats come out in slot order, at most
// one per cycle, while the walk runs. There is no back pressure: each result
// is on out_data for exactly one cycle and must be taken then. Only the
// first eight slots are used, since slot ids are three bits wide.
module multi_slot_timer_table_top #(
  parameter int TIMER_COUNT = 8
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  mstt_pkg::in_t   in_data,
  output logic            out_valid,
  output mstt_pkg::out_t  out_data
);
  import mstt_pkg::*;

  localparam int SLOTS = (TIMER_COUNT < MAX_SLOTS) ? TIMER_COUNT : MAX_SLOTS;
  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH
  } state_t;

  state_t                 state_r;
  logic                   busy_r;
  logic [SLOTS-1:0]       active_r;
  logic [IDX_W-1:0]       idx_r;
  logic [TIME_W-1:0]      now_r;
  logic                   pend_r;
  logic [IDX_W-1:0]       pend_id_r;
  logic                   out_valid_r;
  out_t                   out_data_r;

  // slot payload, written only by add or a periodic refire
  logic                   periodic_r [SLOTS];
  logic [TIME_W-1:0]      wait_r     [SLOTS];
  logic [TIME_W-1:0]      start_r    [SLOTS];

  logic                   accept;
  logic                   due;
  logic                   free_found;
  logic [IDX_W-1:0]       free_idx;
  logic                   cancel_ok;

  assign accept = start && !busy_r;

  // lowest free slot for an add
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!active_r[i]) begin
        free_found = 1'b1;
        free_idx   = IDX_W'(i);
      end
    end
  end

  assign cancel_ok = {1'b0, in_data.cancel_slot} < (SLOT_ID_W + 1)'(SLOTS);

  // one expiry compare per cycle on the slot under the scan index
  mstt_due u_due (
    .now        (now_r),
    .start_time (start_r[idx_r]),
    .wait_time  (wait_r[idx_r]),
    .active     (active_r[idx_r]),
    .due        (due)
  );

  // slot payload writes
  always_ff @(posedge clk) begin
    if (accept && in_data.cmd == CMD_ADD && free_found) begin
      periodic_r[free_idx] <= in_data.periodic;
      wait_r[free_idx]     <= in_data.duration;
      start_r[free_idx]    <= in_data.now;
    end else if (state_r == ST_SCAN && due && periodic_r[idx_r]) begin
      start_r[idx_r] <= now_r;
    end
  end

  // sequencer, active bits and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      busy_r      <= 1'b0;
      active_r    <= '0;
      idx_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            unique case (in_data.cmd)
              CMD_CHECK: begin
                now_r   <= in_data.now;
                idx_r   <= '0;
                pend_r  <= 1'b0;
                busy_r  <= 1'b1;
                state_r <= ST_SCAN;
              end
              CMD_ADD: begin
                out_valid_r <= 1'b1;
                out_data_r.last_flag <= 1'b1;
                if (free_found) begin
                  active_r[free_idx]   <= 1'b1;
                  out_data_r.event_res <= EV_ADDED;
                  out_data_r.slot_id   <= SLOT_ID_W'(free_idx);
                end else begin
                  out_data_r.event_res <= EV_FULL;
                  out_data_r.slot_id   <= '0;
                end
              end
              CMD_CANCEL: begin
                if (cancel_ok) begin
                  active_r[in_data.cancel_slot[IDX_W-1:0]] <= 1'b0;
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_SCAN: begin
          // a new hit releases the previous one as a non-final beat
          if (due) begin
            if (!periodic_r[idx_r]) begin
              active_r[idx_r] <= 1'b0;
            end
            if (pend_r) begin
              out_valid_r          <= 1'b1;
              out_data_r.event_res <= EV_FIRED;
              out_data_r.slot_id   <= SLOT_ID_W'(pend_id_r);
              out_data_r.last_flag <= 1'b0;
            end
            pend_r    <= 1'b1;
            pend_id_r <= idx_r;
          end
          if (idx_r == LAST_IDX) begin
            state_r <= ST_FLUSH;
          end else begin
            idx_r <= idx_r + IDX_W'(1);
          end
        end
        ST_FLUSH: begin
          // held hit is the final beat of this check
          if (pend_r) begin
            out_valid_r          <= 1'b1;
            out_data_r.event_res <= EV_FIRED;
            out_data_r.slot_id   <= SLOT_ID_W'(pend_id_r);
            out_data_r.last_flag <= 1'b1;
          end
          pend_r  <= 1'b0;
          busy_r  <= 1'b0;
          state_r <= ST_IDLE;
        end
        default: begin
          busy_r  <= 1'b0;
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy      = busy_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
